>>> rtl/core/swcrc8_pkg.sv
`default_nettype none
package swcrc8_pkg;

	// Fixed frame geometry and markers.
	localparam int DIST_FRAME_BYTES = 20;
	localparam int SENSOR_COUNT_DEF = 8;
	localparam int WINDOW_MAX_BYTES_DEF = 38;

	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_M = 8'h4D;

	localparam logic [7:0] CRC_POLY = 8'h07;

	// Inertial modes.
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_QUAT  = 2'd1;
	localparam logic [1:0] MODE_EULER = 2'd2;
	localparam logic [1:0] MODE_QACC  = 2'd3;

	// Distance classes.
	localparam logic [1:0] CLS_NORMAL = 2'd0;
	localparam logic [1:0] CLS_CLOSE  = 2'd1;
	localparam logic [1:0] CLS_INVAL  = 2'd2;
	localparam logic [1:0] CLS_RANGE  = 2'd3;

	// Inertial scale codes.
	localparam logic [1:0] SCL_16384 = 2'd0;
	localparam logic [1:0] SCL_16    = 2'd1;
	localparam logic [1:0] SCL_NONE  = 2'd2;

	// Result kinds.
	localparam logic KIND_DIST = 1'b0;
	localparam logic KIND_IMU  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRC_D,
		ST_CHK_D,
		ST_CRC_M,
		ST_CHK_M,
		ST_EMIT_HI,
		ST_EMIT_LO
	} state_t;

	// One byte of CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// Bytes that an inertial frame adds to the window.
	function automatic logic [4:0] imu_extra(input logic [1:0] mode);
		logic [4:0] e;
		unique case (mode)
			MODE_QUAT:  e = 5'd12;
			MODE_EULER: e = 5'd10;
			MODE_QACC:  e = 5'd18;
			default:    e = 5'd0;
		endcase
		return e;
	endfunction

	// Number of inertial values in a frame.
	function automatic logic [2:0] imu_count(input logic [1:0] mode);
		logic [2:0] n;
		unique case (mode)
			MODE_QUAT:  n = 3'd4;
			MODE_EULER: n = 3'd3;
			MODE_QACC:  n = 3'd7;
			default:    n = 3'd0;
		endcase
		return n;
	endfunction

	// Scale code of one inertial component.
	function automatic logic [1:0] imu_scale(input logic [1:0] mode, input logic [2:0] idx);
		logic [1:0] s;
		unique case (mode)
			MODE_EULER: s = SCL_16;
			MODE_QACC:  s = (idx < 3'd4) ? SCL_16384 : SCL_NONE;
			default:    s = SCL_16384;
		endcase
		return s;
	endfunction

	// Special distance codes.
	function automatic logic [1:0] dist_class(input logic [15:0] d);
		logic [1:0] c;
		case (d)
			16'h0000: c = CLS_CLOSE;
			16'h0001: c = CLS_INVAL;
			16'hFFFF: c = CLS_RANGE;
			default:  c = CLS_NORMAL;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/sliding_window_crc8_frame_decoder_top.sv
`default_nettype none
// Frame decoder for a byte stream. Each accepted item is one received byte; it is
// shifted into a window of the last 20 bytes (plus 12, 10 or 18 bytes when
// imu_mode selects quaternion, euler or quaternion plus acceleration and the
// window is large enough). A distance frame ('T','H', CRC-8 poly 0x07 over 19
// bytes) yields SENSOR_COUNT distance items, then an inertial frame ('I','M',
// own CRC-8) yields its signed words; tlast marks the final item of a byte.
// One shared bytewise CRC unit walks the window one byte per cycle, and the
// results are read out one byte per cycle while the output is not stalled.
// s_tready is low during that work, so no new byte is taken until the
// sequencer is back in idle. Writing imu_mode clears the window to zeros.
module sliding_window_crc8_frame_decoder_top #(
	parameter int SENSOR_COUNT     = swcrc8_pkg::SENSOR_COUNT_DEF,
	parameter int WINDOW_MAX_BYTES = swcrc8_pkg::WINDOW_MAX_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: imu_mode.
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_wdata,
	// Input bytes. s_tdata: rx_byte[7:0].
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	// Results. m_tdata: item_index[2:0], raw_value[18:3], distance_class[20:19],
	// scale_code[22:21], sensor_valid[23]. m_tuser: kind[0].
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,
	output logic [0:0]       m_tuser,
	output logic             m_tlast
);

	localparam int DFB       = swcrc8_pkg::DIST_FRAME_BYTES;
	localparam int IMU_SPAN  = WINDOW_MAX_BYTES - DFB;
	localparam int IMU_DEPTH = (IMU_SPAN > 0) ? IMU_SPAN : 1;
	localparam int D_AW      = $clog2(DFB);
	localparam int M_AW      = (IMU_DEPTH > 1) ? $clog2(IMU_DEPTH) : 1;
	localparam int CNT_MAX   = (IMU_DEPTH > DFB) ? IMU_DEPTH : DFB;
	localparam int CW        = $clog2(CNT_MAX + 1);

	swcrc8_pkg::state_t state_q, state_d;

	logic [1:0]    mode_q;
	logic [7:0]    d_q [DFB];
	logic [7:0]    m_q [IMU_DEPTH];
	logic [7:0]    d_up [DFB];
	logic [7:0]    m_up [IMU_DEPTH];
	logic [CW-1:0] cnt_q;
	logic [7:0]    crc_q;
	logic          t_ok_q, h_ok_q, i_ok_q, mk_ok_q;
	logic [7:0]    mask_q;
	logic          dist_ok_q, imu_ok_q;
	logic          kind_q;
	logic [2:0]    idx_q;
	logic [7:0]    hi_q;

	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;
	logic          m_tuser_q;
	logic          m_tlast_q;

	// Mode decode.
	logic [4:0]    extra;
	logic          imu_act;
	logic [CW-1:0] extra_cw;
	logic [2:0]    imu_cnt;
	assign extra    = swcrc8_pkg::imu_extra(mode_q);
	assign imu_act  = (mode_q != swcrc8_pkg::MODE_OFF) &&
		(({2'b00, extra} + 7'(DFB)) <= 7'(WINDOW_MAX_BYTES));
	assign extra_cw = CW'(extra);
	assign imu_cnt  = swcrc8_pkg::imu_count(mode_q);

	// Handshake and control decode.
	logic in_acc, out_free, rd_sel_m, crc_d_end, crc_m_end, crc_match, last_res;
	logic [7:0] rd_byte, rd_d, rd_m;
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign rd_d     = d_q[cnt_q[D_AW-1:0]];
	assign rd_m     = m_q[cnt_q[M_AW-1:0]];
	assign rd_byte  = rd_sel_m ? rd_m : rd_d;
	assign crc_d_end = (cnt_q == CW'(DFB - 2));
	assign crc_m_end = (cnt_q == (extra_cw - CW'(2)));
	assign crc_match = (crc_q == rd_byte);
	assign last_res  = (kind_q == swcrc8_pkg::KIND_DIST)
		? ((idx_q == 3'(SENSOR_COUNT - 1)) && !imu_ok_q)
		: (idx_q == (imu_cnt - 3'd1));

	// Neighbor taps for the shift line.
	for (genvar j = 0; j < DFB; j++) begin : g_dup
		if (j < DFB - 1) begin : g_in
			assign d_up[j] = d_q[j+1];
		end else begin : g_end
			assign d_up[j] = imu_act ? m_q[0] : s_tdata;
		end
	end
	for (genvar j = 0; j < IMU_DEPTH; j++) begin : g_mup
		if (j < IMU_DEPTH - 1) begin : g_in
			assign m_up[j] = m_q[j+1];
		end else begin : g_end
			assign m_up[j] = 8'h00;
		end
	end

	// Byte source of the shared CRC unit and of the result readout.
	always_comb begin
		unique case (state_q)
			swcrc8_pkg::ST_CRC_M, swcrc8_pkg::ST_CHK_M: rd_sel_m = 1'b1;
			swcrc8_pkg::ST_EMIT_HI, swcrc8_pkg::ST_EMIT_LO: rd_sel_m = kind_q;
			default: rd_sel_m = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swcrc8_pkg::ST_IDLE:
				if (in_acc) state_d = swcrc8_pkg::ST_CRC_D;
			swcrc8_pkg::ST_CRC_D:
				if (crc_d_end) state_d = swcrc8_pkg::ST_CHK_D;
			swcrc8_pkg::ST_CHK_D: begin
				if (imu_act) begin
					state_d = swcrc8_pkg::ST_CRC_M;
				end else if (t_ok_q && h_ok_q && crc_match) begin
					state_d = swcrc8_pkg::ST_EMIT_HI;
				end else begin
					state_d = swcrc8_pkg::ST_IDLE;
				end
			end
			swcrc8_pkg::ST_CRC_M:
				if (crc_m_end) state_d = swcrc8_pkg::ST_CHK_M;
			swcrc8_pkg::ST_CHK_M: begin
				if (dist_ok_q || (i_ok_q && mk_ok_q && crc_match)) begin
					state_d = swcrc8_pkg::ST_EMIT_HI;
				end else begin
					state_d = swcrc8_pkg::ST_IDLE;
				end
			end
			swcrc8_pkg::ST_EMIT_HI:
				state_d = swcrc8_pkg::ST_EMIT_LO;
			swcrc8_pkg::ST_EMIT_LO: begin
				if (out_free) begin
					state_d = (last_res ? swcrc8_pkg::ST_IDLE : swcrc8_pkg::ST_EMIT_HI);
				end
			end
			default: state_d = swcrc8_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swcrc8_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration register and the byte window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= swcrc8_pkg::MODE_OFF;
			for (int j = 0; j < DFB; j++) d_q[j] <= 8'h00;
			for (int j = 0; j < IMU_DEPTH; j++) m_q[j] <= 8'h00;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			for (int j = 0; j < DFB; j++) d_q[j] <= 8'h00;
			for (int j = 0; j < IMU_DEPTH; j++) m_q[j] <= 8'h00;
		end else if (in_acc) begin
			for (int j = 0; j < DFB; j++) d_q[j] <= d_up[j];
			if (imu_act) begin
				for (int j = 0; j < IMU_DEPTH; j++) begin
					if (CW'(j) == (extra_cw - CW'(1))) begin
						m_q[j] <= s_tdata;
					end else if (CW'(j) < (extra_cw - CW'(1))) begin
						m_q[j] <= m_up[j];
					end
				end
			end
		end
	end

	// Sequencer datapath: shared CRC unit, frame checks and result readout.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= 8'h00;
			dist_ok_q <= 1'b0;
			imu_ok_q  <= 1'b0;
			kind_q    <= swcrc8_pkg::KIND_DIST;
			idx_q     <= 3'd0;
		end else begin
			unique case (state_q)
				swcrc8_pkg::ST_IDLE: begin
					cnt_q     <= '0;
					crc_q     <= 8'h00;
					dist_ok_q <= 1'b0;
					imu_ok_q  <= 1'b0;
				end
				swcrc8_pkg::ST_CRC_D: begin
					crc_q <= swcrc8_pkg::crc8_byte(crc_q, rd_byte);
					cnt_q <= cnt_q + CW'(1);
				end
				swcrc8_pkg::ST_CHK_D: begin
					dist_ok_q <= t_ok_q && h_ok_q && crc_match;
					crc_q     <= 8'h00;
					cnt_q     <= imu_act ? CW'(0) : CW'(2);
					kind_q    <= swcrc8_pkg::KIND_DIST;
					idx_q     <= 3'd0;
				end
				swcrc8_pkg::ST_CRC_M: begin
					crc_q <= swcrc8_pkg::crc8_byte(crc_q, rd_byte);
					cnt_q <= cnt_q + CW'(1);
				end
				swcrc8_pkg::ST_CHK_M: begin
					imu_ok_q <= i_ok_q && mk_ok_q && crc_match;
					idx_q    <= 3'd0;
					if (dist_ok_q) begin
						kind_q <= swcrc8_pkg::KIND_DIST;
						cnt_q  <= CW'(2);
					end else begin
						kind_q <= swcrc8_pkg::KIND_IMU;
						cnt_q  <= CW'(3);
					end
				end
				swcrc8_pkg::ST_EMIT_HI: begin
					cnt_q <= cnt_q + CW'(1);
				end
				swcrc8_pkg::ST_EMIT_LO: begin
					if (out_free) begin
						if (kind_q == swcrc8_pkg::KIND_DIST &&
							idx_q == 3'(SENSOR_COUNT - 1)) begin
							kind_q <= swcrc8_pkg::KIND_IMU;
							cnt_q  <= CW'(3);
							idx_q  <= 3'd0;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	// Header and mask bytes picked up while the CRC unit walks past them.
	always_ff @(posedge clk) begin
		if (state_q == swcrc8_pkg::ST_CRC_D) begin
			if (cnt_q == CW'(0)) t_ok_q <= (rd_byte == swcrc8_pkg::CH_T);
			if (cnt_q == CW'(1)) h_ok_q <= (rd_byte == swcrc8_pkg::CH_H);
			if (cnt_q == CW'(DFB - 2)) mask_q <= rd_byte;
		end
		if (state_q == swcrc8_pkg::ST_CRC_M) begin
			if (cnt_q == CW'(0)) i_ok_q  <= (rd_byte == swcrc8_pkg::CH_I);
			if (cnt_q == CW'(1)) mk_ok_q <= (rd_byte == swcrc8_pkg::CH_M);
		end
		if (state_q == swcrc8_pkg::ST_EMIT_HI) hi_q <= rd_byte;
	end

	// Output register: a finished item waits here until taken.
	logic [15:0] word;
	logic [1:0]  res_cls, res_scale;
	logic        res_valid;
	assign word      = {hi_q, rd_byte};
	assign res_cls   = (kind_q == swcrc8_pkg::KIND_DIST) ? swcrc8_pkg::dist_class(word)
		: swcrc8_pkg::CLS_NORMAL;
	assign res_scale = (kind_q == swcrc8_pkg::KIND_IMU) ? swcrc8_pkg::imu_scale(mode_q, idx_q)
		: swcrc8_pkg::SCL_16384;
	assign res_valid = (kind_q == swcrc8_pkg::KIND_DIST) ? mask_q[idx_q] : 1'b0;

	logic load_out;
	assign load_out = (state_q == swcrc8_pkg::ST_EMIT_LO) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {res_valid, res_scale, res_cls, word, idx_q};
			m_tuser_q <= kind_q;
			m_tlast_q <= last_res;
		end
	end

	assign s_tready = (state_q == swcrc8_pkg::ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire

>>> verif/sliding_window_crc8_frame_decoder_top_tb.sv
module sliding_window_crc8_frame_decoder_top_tb;

	localparam int SENSORS = swcrc8_pkg::SENSOR_COUNT_DEF;
	localparam int WIN_MAX = swcrc8_pkg::WINDOW_MAX_BYTES_DEF;
	localparam int DFB = swcrc8_pkg::DIST_FRAME_BYTES;
	localparam int DRAIN_CYCLES = 120;
	localparam int LONG_HOLD = 600;
	localparam int CYCLE_LIMIT = 2000000;

	// One decoded result as the block should present it.
	typedef struct packed {
		logic        kind;
		logic [2:0]  slot;
		logic [15:0] raw;
		logic [1:0]  cls;
		logic [1:0]  scale;
		logic        valid;
		logic        last;
	} sensor_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	sliding_window_crc8_frame_decoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Bytes waiting to be sent and results waiting to arrive.
	logic [7:0] byte_q [$];
	sensor_result_t results_due [$];

	// Predictor state: the byte window and the current inertial mode.
	logic [7:0] rx_window [0:WIN_MAX-1];
	logic [1:0] mode_now = swcrc8_pkg::MODE_OFF;

	// Scratch frame that the stimulus tasks build before queueing.
	logic [7:0] staged [0:WIN_MAX-1];

	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned dist_seen = 0;
	int unsigned imu_seen = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	logic byte_taken = 1'b0;
	logic no_idle = 1'b0;
	logic long_hold_req = 1'b0;
	logic long_hold_done = 1'b0;
	logic [3:0] modes_used = 4'd0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle counter with a hard stop.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// Bytes added to the window by an inertial frame in each mode.
	function automatic int unsigned imu_span(input logic [1:0] mode);
		case (mode)
			swcrc8_pkg::MODE_QUAT:  return 12;
			swcrc8_pkg::MODE_EULER: return 10;
			swcrc8_pkg::MODE_QACC:  return 18;
			default:                return 0;
		endcase
	endfunction

	function automatic int unsigned imu_values(input logic [1:0] mode);
		case (mode)
			swcrc8_pkg::MODE_QUAT:  return 4;
			swcrc8_pkg::MODE_EULER: return 3;
			swcrc8_pkg::MODE_QACC:  return 7;
			default:                return 0;
		endcase
	endfunction

	// Bitwise CRC-8, MSB first, folded in one byte at a time.
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
		logic [7:0] c;
		c = acc ^ d;
		for (int k = 0; k < 8; k++)
			c = c[7] ? ((c << 1) ^ swcrc8_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	function automatic logic [7:0] window_crc(input int unsigned from, input int unsigned n);
		logic [7:0] acc;
		acc = 8'd0;
		for (int unsigned i = 0; i < n; i++)
			acc = crc8_step(acc, rx_window[from + i]);
		return acc;
	endfunction

	// Shift one accepted byte into the window and queue the results it causes.
	task automatic decode_byte(input logic [7:0] b);
		int unsigned len, total, k;
		logic dist_hit, imu_hit;
		logic [15:0] w;
		sensor_result_t r;
		len = DFB + imu_span(mode_now);
		for (int unsigned i = 0; i + 1 < len; i++)
			rx_window[i] = rx_window[i + 1];
		rx_window[len - 1] = b;
		dist_hit = rx_window[0] == swcrc8_pkg::CH_T && rx_window[1] == swcrc8_pkg::CH_H &&
			rx_window[DFB - 1] == window_crc(0, DFB - 1);
		imu_hit = 1'b0;
		if (mode_now != swcrc8_pkg::MODE_OFF) begin
			imu_hit = rx_window[DFB] == swcrc8_pkg::CH_I &&
				rx_window[DFB + 1] == swcrc8_pkg::CH_M &&
				rx_window[len - 1] == window_crc(DFB, len - DFB - 1);
		end
		total = (dist_hit ? SENSORS : 0) + (imu_hit ? imu_values(mode_now) : 0);
		k = 0;
		if (dist_hit) begin
			for (int i = 0; i < SENSORS; i++) begin
				w = {rx_window[2 + 2 * i], rx_window[3 + 2 * i]};
				r.kind = swcrc8_pkg::KIND_DIST;
				r.slot = 3'(i);
				r.raw = w;
				if (w == 16'h0000)
					r.cls = swcrc8_pkg::CLS_CLOSE;
				else if (w == 16'h0001)
					r.cls = swcrc8_pkg::CLS_INVAL;
				else if (w == 16'hFFFF)
					r.cls = swcrc8_pkg::CLS_RANGE;
				else
					r.cls = swcrc8_pkg::CLS_NORMAL;
				r.scale = swcrc8_pkg::SCL_16384;
				r.valid = rx_window[DFB - 2][i];
				r.last = (k == total - 1);
				results_due.insert(results_due.size(), r);
				k++;
			end
		end
		if (imu_hit) begin
			for (int i = 0; i < imu_values(mode_now); i++) begin
				r.kind = swcrc8_pkg::KIND_IMU;
				r.slot = 3'(i);
				r.raw = {rx_window[DFB + 3 + 2 * i], rx_window[DFB + 4 + 2 * i]};
				r.cls = swcrc8_pkg::CLS_NORMAL;
				if (mode_now == swcrc8_pkg::MODE_EULER)
					r.scale = swcrc8_pkg::SCL_16;
				else if (mode_now == swcrc8_pkg::MODE_QACC && i >= 4)
					r.scale = swcrc8_pkg::SCL_NONE;
				else
					r.scale = swcrc8_pkg::SCL_16384;
				r.valid = 1'b0;
				r.last = (k == total - 1);
				results_due.insert(results_due.size(), r);
				k++;
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Input and output monitor: configuration, accepted bytes, checked results.
	always @(posedge clk) begin
		sensor_result_t want;
		byte_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (cfg_we) begin
				mode_now = cfg_wdata;
				modes_used[cfg_wdata] = 1'b1;
				for (int i = 0; i < WIN_MAX; i++)
					rx_window[i] = 8'd0;
			end
			if (s_tvalid && s_tready) begin
				bytes_accepted++;
				decode_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected item, expected none, actual tdata %h tuser %h tlast %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = results_due.pop_front();
					check_field("kind", want.kind, m_tuser[0]);
					check_field("item_index", want.slot, m_tdata[2:0]);
					check_field("raw_value", want.raw, m_tdata[18:3]);
					check_field("distance_class", want.cls, m_tdata[20:19]);
					check_field("scale_code", want.scale, m_tdata[22:21]);
					check_field("sensor_valid", want.valid, m_tdata[23]);
					check_field("last", want.last, m_tlast);
					if (want.kind == swcrc8_pkg::KIND_IMU)
						imu_seen++;
					else
						dist_seen++;
				end
			end
		end
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	// Byte sender: offers the next queued byte once the previous one is taken.
	always @(negedge clk) begin
		if (!s_tvalid || byte_taken) begin
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (byte_q.size() > 0) begin
				s_tdata <= byte_q.pop_front();
				s_tvalid <= 1'b1;
				gap_left = idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off once an item waits.
	always @(negedge clk) begin
		if (long_hold_req && !long_hold_done && m_tvalid) begin
			long_hold_done = 1'b1;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = idle_len();
		end
	end

	// Build a distance frame in the scratch buffer.
	task automatic stage_dist(input logic [7:0][15:0] words, input logic [7:0] mask);
		logic [7:0] acc;
		staged[0] = swcrc8_pkg::CH_T;
		staged[1] = swcrc8_pkg::CH_H;
		for (int i = 0; i < 8; i++) begin
			staged[2 + 2 * i] = words[i][15:8];
			staged[3 + 2 * i] = words[i][7:0];
		end
		staged[DFB - 2] = mask;
		acc = 8'd0;
		for (int i = 0; i < DFB - 1; i++)
			acc = crc8_step(acc, staged[i]);
		staged[DFB - 1] = acc;
	endtask

	// Build an inertial frame for the given mode in the scratch buffer.
	task automatic stage_imu(input logic [1:0] mode, input logic [6:0][15:0] words);
		int unsigned len;
		logic [7:0] acc;
		len = imu_span(mode);
		staged[0] = swcrc8_pkg::CH_I;
		staged[1] = swcrc8_pkg::CH_M;
		staged[2] = 8'($urandom_range(0, 255));
		for (int i = 0; i < imu_values(mode); i++) begin
			staged[3 + 2 * i] = words[i][15:8];
			staged[4 + 2 * i] = words[i][7:0];
		end
		acc = 8'd0;
		for (int i = 0; i < len - 1; i++)
			acc = crc8_step(acc, staged[i]);
		staged[len - 1] = acc;
	endtask

	// Queue scratch bytes [from, upto), corrupting one byte if flip_at is in range.
	task automatic send_staged(input int from, input int upto, input int flip_at);
		for (int i = from; i < upto; i++) begin
			if (i == flip_at)
				byte_q.insert(byte_q.size(), staged[i] ^ 8'($urandom_range(1, 255)));
			else
				byte_q.insert(byte_q.size(), staged[i]);
			bytes_queued++;
		end
	endtask

	task automatic send_noise(input int n);
		for (int i = 0; i < n; i++)
			staged[i] = 8'($urandom_range(0, 255));
		send_staged(0, n, -1);
	endtask

	// Distance and inertial words lean toward the special codes and extremes.
	function automatic logic [15:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'hFFFF;
			3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Wait until the block has drained every expected result and gone quiet.
	task automatic settle();
		while (byte_q.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] mode);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic: mostly good frames, some corrupted ones, some line noise.
	task automatic fill_random(input logic [1:0] mode, input int unsigned nbytes);
		int unsigned goal, pick, shape;
		logic broken, hit_dist;
		logic [7:0][15:0] dw;
		logic [6:0][15:0] iw;
		goal = bytes_queued + nbytes;
		while (bytes_queued < goal) begin
			pick = $urandom_range(0, 9);
			for (int i = 0; i < 8; i++)
				dw[i] = rand_word();
			for (int i = 0; i < 7; i++)
				iw[i] = rand_word();
			if (pick == 9) begin
				send_noise(int'($urandom_range(1, 8)));
			end else begin
				broken = pick >= 7;
				hit_dist = 1'($urandom_range(0, 1));
				shape = (mode == swcrc8_pkg::MODE_OFF) ? 0 : $urandom_range(0, 2);
				if (shape != 2) begin
					stage_dist(dw, 8'($urandom_range(0, 255)));
					send_staged(0, DFB,
						(broken && (hit_dist || shape == 0)) ?
						int'($urandom_range(0, 19)) : -1);
				end
				if (shape != 0) begin
					stage_imu(mode, iw);
					send_staged(0, imu_span(mode),
						(broken && (!hit_dist || shape == 2)) ?
						int'($urandom_range(0, imu_span(mode) - 1)) : -1);
				end
			end
		end
	endtask

	initial begin
		logic [7:0][15:0] dw;
		logic [6:0][15:0] iw;
		logic [1:0] plan [0:7];

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, mode off: special distance codes, a bad CRC, all and no mask bits.
		dw = {16'h1234, 16'h7FFF, 16'h8000, 16'h0002, 16'hFFFE, 16'hFFFF, 16'h0001, 16'h0000};
		stage_dist(dw, 8'hA5);
		send_staged(0, DFB, -1);
		stage_dist(dw, 8'h5A);
		send_staged(0, DFB, DFB - 1);
		dw = {8{16'hFFFF}};
		stage_dist(dw, 8'hFF);
		send_staged(0, DFB, -1);
		dw = {8{16'h0000}};
		stage_dist(dw, 8'h00);
		send_staged(0, DFB, -1);

		// Rewriting the same mode must clear a half-received frame.
		stage_dist({8{16'h0101}}, 8'h3C);
		send_staged(0, DFB - 1, -1);
		settle();
		write_mode(swcrc8_pkg::MODE_OFF);
		send_staged(DFB - 1, DFB, -1);
		settle();

		// Quaternion: both frames ending on one byte, then an inertial frame alone.
		write_mode(swcrc8_pkg::MODE_QUAT);
		iw = {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
		stage_dist({16'h0001, 16'h00FF, 16'hFF00, 16'h0000, 16'hFFFF, 16'h4000, 16'h0100,
			16'h0010}, 8'h81);
		send_staged(0, DFB, -1);
		stage_imu(swcrc8_pkg::MODE_QUAT, iw);
		send_staged(0, imu_span(swcrc8_pkg::MODE_QUAT), -1);
		send_noise(DFB);
		stage_imu(swcrc8_pkg::MODE_QUAT, iw);
		send_staged(0, imu_span(swcrc8_pkg::MODE_QUAT), -1);
		settle();

		// Euler angles.
		write_mode(swcrc8_pkg::MODE_EULER);
		stage_dist({8{16'hABCD}}, 8'h0F);
		send_staged(0, DFB, -1);
		stage_imu(swcrc8_pkg::MODE_EULER,
			{16'h0, 16'h0, 16'h0, 16'h0, 16'h8000, 16'hFFFF, 16'h7FFF});
		send_staged(0, imu_span(swcrc8_pkg::MODE_EULER), -1);
		settle();

		// Quaternion plus acceleration: the largest burst of results per byte, with the
		// receiver holding off long while the next frame keeps coming.
		write_mode(swcrc8_pkg::MODE_QACC);
		long_hold_req = 1'b1;
		for (int n = 0; n < 2; n++) begin
			for (int i = 0; i < 8; i++)
				dw[i] = rand_word();
			stage_dist(dw, 8'($urandom_range(0, 255)));
			send_staged(0, DFB, -1);
			stage_imu(swcrc8_pkg::MODE_QACC, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
				16'h0000, 16'h1234, 16'hEDCB});
			send_staged(0, imu_span(swcrc8_pkg::MODE_QACC), -1);
		end
		settle();

		// Random phases across all modes, extremes included.
		plan = '{swcrc8_pkg::MODE_OFF, swcrc8_pkg::MODE_QACC, swcrc8_pkg::MODE_QUAT,
			swcrc8_pkg::MODE_EULER, swcrc8_pkg::MODE_QACC, swcrc8_pkg::MODE_OFF,
			swcrc8_pkg::MODE_EULER, swcrc8_pkg::MODE_QUAT};
		for (int p = 0; p < 8; p++) begin
			write_mode(plan[p]);
			no_idle = ($urandom_range(0, 3) == 0);
			fill_random(plan[p], 14);
			settle();
		end
		no_idle = 1'b0;

		if (results_due.size() != 0) begin
			errors += results_due.size();
			$display("%0t: %0d expected items never arrived", $time, results_due.size());
		end
		$display("Run covered %0d received bytes over imu modes %b (bit per mode).",
			bytes_accepted, modes_used);
		$display("Checked %0d distance and %0d inertial items, %0d errors.",
			dist_seen, imu_seen, errors);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
